>>> rtl/assert_macros.svh
// assertion macros used by the checker in litc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, quiet in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/litc_pkg.sv
package litc_pkg;

    localparam int IDX_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 64;
    localparam int NUM_DIMS_W = 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int DIV_STAGES = IDX_W;

    // register map, byte address is four times the index
    typedef enum logic [2:0] {
        REG_NUM_DIMS   = 3'd0,
        REG_DIM_SIZE_0 = 3'd1,
        REG_DIM_SIZE_1 = 3'd2,
        REG_DIM_SIZE_2 = 3'd3,
        REG_DIM_SIZE_3 = 3'd4
    } litc_reg_t;

    // data that rides alongside a divider pipeline
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [SIZE_W-1:0] coord_3;
        logic [SIZE_W-1:0] coord_2;
    } litc_side_t;

endpackage

>>> rtl/litc_if.sv
interface litc_index_if;
    logic        valid;
    logic        ready;
    logic [31:0] linear_index;

    modport source (output valid, output linear_index, input ready);
    modport sink (input valid, input linear_index, output ready);
endinterface

interface litc_coord_if;
    logic        valid;
    logic        ready;
    logic [15:0] coord_0;
    logic [15:0] coord_1;
    logic [15:0] coord_2;
    logic [15:0] coord_3;
    logic        out_of_range;
    logic        config_error;

    modport source (output valid, output coord_0, output coord_1, output coord_2,
                    output coord_3, output out_of_range, output config_error,
                    input ready);
    modport sink (input valid, input coord_0, input coord_1, input coord_2,
                  input coord_3, input out_of_range, input config_error,
                  output ready);
endinterface

>>> rtl/litc_div.sv
module litc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [litc_pkg::IDX_W-1:0]  num,
    input  logic [litc_pkg::SIZE_W-1:0] den,
    input  litc_pkg::litc_side_t       in_side,
    output logic                       out_valid,
    output logic [litc_pkg::IDX_W-1:0]  quo,
    output logic [litc_pkg::SIZE_W-1:0] rem,
    output litc_pkg::litc_side_t       out_side
);
    import litc_pkg::*;

    // one restoring step per stage, dividend bits shift out as quotient bits shift in
    logic              v_reg    [DIV_STAGES];
    logic [IDX_W-1:0]  acc_reg  [DIV_STAGES];
    logic [SIZE_W-1:0] rem_reg  [DIV_STAGES];
    litc_side_t        side_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic              v_in;
        logic [IDX_W-1:0]  acc_in;
        logic [SIZE_W-1:0] rem_in;
        litc_side_t        side_in;
        logic [SIZE_W:0]   trial;
        logic [SIZE_W:0]   diff;
        logic              ge;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign acc_in  = num;
            assign rem_in  = '0;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign v_in    = v_reg[s-1];
            assign acc_in  = acc_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign trial = {rem_in, acc_in[IDX_W-1]};
        assign ge    = trial >= {1'b0, den};
        assign diff  = trial - {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s]  <= {acc_in[IDX_W-2:0], ge};
                rem_reg[s]  <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign quo       = acc_reg[DIV_STAGES-1];
    assign rem       = rem_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

>>> rtl/linear_index_to_coordinates.sv
// Row-major linear index to coordinates. Each beat on index_ch carries a flat
// element index; one beat leaves on coord_ch with the coordinate along each
// of up to four dimensions (dimension 0 outermost), zero for dimensions not in
// use. An index at or beyond the element count gives out_of_range and zero
// coordinates; config_error flags an element count above 32 bits, and the
// coordinates are then still exact. A new index is taken every cycle while the
// output is free or being drained. Three chained restoring dividers of 32
// stages each, one quotient bit per stage, peel the innermost three
// coordinates off by the dimension sizes, then one output register holds
// the beat. A stall on coord_ch freezes the whole pipeline. Configuration is
// written through the APB port (registers at byte addresses 0, 4, .. 16:
// num_dims, dim_size_0 .. dim_size_3) and must only change while the block
// is empty; the element count is registered from the products after a write.
module linear_index_to_coordinates #(
    parameter int MAX_DIMENSIONS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    litc_index_if.sink                  index_ch,
    litc_coord_if.source                coord_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [litc_pkg::ADDR_W-1:0] paddr,
    input  logic [litc_pkg::DATA_W-1:0] pwdata,
    output logic [litc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import litc_pkg::*;

    // dimension limit, never above the four coordinate outputs
    localparam int DIM_LIMIT = (MAX_DIMENSIONS < 4) ? MAX_DIMENSIONS : 4;
    localparam logic [NUM_DIMS_W-1:0] DIM_LIM = NUM_DIMS_W'(DIM_LIMIT);

    // configuration registers
    logic [NUM_DIMS_W-1:0] num_dims_reg;
    logic [SIZE_W-1:0]     dim_size_reg [4];
    logic                  wr_en;
    litc_reg_t             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = litc_reg_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg    <= NUM_DIMS_W'(4);
            dim_size_reg[0] <= SIZE_W'(1);
            dim_size_reg[1] <= SIZE_W'(1);
            dim_size_reg[2] <= SIZE_W'(1);
            dim_size_reg[3] <= SIZE_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_NUM_DIMS:   num_dims_reg    <= pwdata[NUM_DIMS_W-1:0];
                REG_DIM_SIZE_0: dim_size_reg[0] <= pwdata[SIZE_W-1:0];
                REG_DIM_SIZE_1: dim_size_reg[1] <= pwdata[SIZE_W-1:0];
                REG_DIM_SIZE_2: dim_size_reg[2] <= pwdata[SIZE_W-1:0];
                REG_DIM_SIZE_3: dim_size_reg[3] <= pwdata[SIZE_W-1:0];
                default: ;  // writes beyond the map are dropped
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_NUM_DIMS:   prdata = DATA_W'(num_dims_reg);
            REG_DIM_SIZE_0: prdata = DATA_W'(dim_size_reg[0]);
            REG_DIM_SIZE_1: prdata = DATA_W'(dim_size_reg[1]);
            REG_DIM_SIZE_2: prdata = DATA_W'(dim_size_reg[2]);
            REG_DIM_SIZE_3: prdata = DATA_W'(dim_size_reg[3]);
            default:        prdata = '0;
        endcase
    end

    // dimensions in use: zero counts as one, anything above the limit saturates
    logic [NUM_DIMS_W-1:0] dims_used;
    logic [SIZE_W-1:0]     divisor [4];

    always_comb
    begin
        if (num_dims_reg == '0)
        begin
            dims_used = NUM_DIMS_W'(1);
        end
        else if (num_dims_reg > DIM_LIM)
        begin
            dims_used = DIM_LIM;
        end
        else
        begin
            dims_used = num_dims_reg;
        end
    end

    // an unused dimension divides by one, leaving remainder zero and the quotient whole
    for (genvar i = 0; i < 4; i++) begin : g_divisor
        assign divisor[i] = (NUM_DIMS_W'(i) < dims_used) ? dim_size_reg[i] : SIZE_W'(1);
    end

    // element count, two multiplier stages behind the configuration
    logic [2*SIZE_W-1:0] prod_lo_reg;
    logic [2*SIZE_W-1:0] prod_hi_reg;
    logic [COUNT_W-1:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_lo_reg <= (2*SIZE_W)'(1);
            prod_hi_reg <= (2*SIZE_W)'(1);
            count_reg   <= COUNT_W'(1);
        end
        else
        begin
            prod_lo_reg <= divisor[0] * divisor[1];
            prod_hi_reg <= divisor[2] * divisor[3];
            count_reg   <= prod_lo_reg * prod_hi_reg;
        end
    end

    // whole pipeline advances together when the output register can take a beat
    logic out_valid_reg;
    logic advance;

    assign advance        = !out_valid_reg || coord_ch.ready;
    assign index_ch.ready = advance;

    // divider chain: innermost dimension first
    litc_side_t        side_a, side_b, side_c, side_d;
    logic              v_a, v_b, v_c;
    logic [IDX_W-1:0]  quo_a, quo_b, quo_c;
    logic [SIZE_W-1:0] rem_a, rem_b, rem_c;

    assign side_a = '{index: index_ch.linear_index, coord_3: '0, coord_2: '0};

    litc_div u_div_3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (index_ch.valid),
        .num      (index_ch.linear_index),
        .den      (divisor[3]),
        .in_side  (side_a),
        .out_valid(v_a),
        .quo      (quo_a),
        .rem      (rem_a),
        .out_side (side_b)
    );

    litc_side_t side_b_fwd;
    assign side_b_fwd = '{index: side_b.index, coord_3: rem_a, coord_2: '0};

    litc_div u_div_2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (v_a),
        .num      (quo_a),
        .den      (divisor[2]),
        .in_side  (side_b_fwd),
        .out_valid(v_b),
        .quo      (quo_b),
        .rem      (rem_b),
        .out_side (side_c)
    );

    litc_side_t side_c_fwd;
    assign side_c_fwd = '{index: side_c.index, coord_3: side_c.coord_3, coord_2: rem_b};

    litc_div u_div_1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (v_b),
        .num      (quo_b),
        .den      (divisor[1]),
        .in_side  (side_c_fwd),
        .out_valid(v_c),
        .quo      (quo_c),
        .rem      (rem_c),
        .out_side (side_d)
    );

    // range check against the element count; an oversized tensor holds every index
    logic cfg_err;
    logic oor;

    assign cfg_err = count_reg[COUNT_W-1:IDX_W] != '0;
    assign oor     = !cfg_err && (side_d.index >= count_reg[IDX_W-1:0]);

    logic [SIZE_W-1:0] coord_reg [4];
    logic              oor_reg;
    logic              cfg_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= v_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // outermost coordinate is whatever quotient is left
            coord_reg[0] <= oor ? '0 : quo_c[SIZE_W-1:0];
            coord_reg[1] <= oor ? '0 : rem_c;
            coord_reg[2] <= oor ? '0 : side_d.coord_2;
            coord_reg[3] <= oor ? '0 : side_d.coord_3;
            oor_reg      <= oor;
            cfg_err_reg  <= cfg_err;
        end
    end

    assign coord_ch.valid        = out_valid_reg;
    assign coord_ch.coord_0      = coord_reg[0];
    assign coord_ch.coord_1      = coord_reg[1];
    assign coord_ch.coord_2      = coord_reg[2];
    assign coord_ch.coord_3      = coord_reg[3];
    assign coord_ch.out_of_range = oor_reg;
    assign coord_ch.config_error = cfg_err_reg;

endmodule

>>> rtl/litc_checker.sv
module litc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] coord_0,
    input logic [15:0] coord_1,
    input logic [15:0] coord_2,
    input logic [15:0] coord_3,
    input logic        out_of_range,
    input logic        config_error,
    input logic        pready
);
`include "assert_macros.svh"

    // a stalled beat stays put
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(coord_0) && $stable(coord_3) && $stable(out_of_range))

    // out-of-range beats carry zero coordinates
    `ASSERT_IMPLIES(a_oor_zero, clk, rst_n, out_valid && out_of_range, coord_0 == 16'd0 && coord_1 == 16'd0 && coord_2 == 16'd0 && coord_3 == 16'd0)

    // an oversized tensor holds every index
    `ASSERT_IMPLIES(a_err_in_range, clk, rst_n, out_valid && config_error, !out_of_range)

    // register port never waits
    `ASSERT_IMPLIES(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind linear_index_to_coordinates litc_checker u_litc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (coord_ch.valid),
    .out_ready   (coord_ch.ready),
    .coord_0     (coord_ch.coord_0),
    .coord_1     (coord_ch.coord_1),
    .coord_2     (coord_ch.coord_2),
    .coord_3     (coord_ch.coord_3),
    .out_of_range(coord_ch.out_of_range),
    .config_error(coord_ch.config_error),
    .pready      (pready)
);
